FILE: rtl/b64e_pkg.sv
// b64e_pkg: shared types, constants and the base64 alphabet lookup
// used by the front, queue, back and top level of the base64 stream encoder
// depends on: nothing
`default_nettype none

package b64e_pkg;

  // ascii code of the padding character
  localparam logic [6:0] PAD_CHAR = 7'h3D;

  // most characters one input byte can produce
  localparam int unsigned MAX_CHARS = 4;

  // position of a byte in its 3-byte group
  typedef enum logic [1:0] {
    POS_FIRST  = 2'd0,
    POS_SECOND = 2'd1,
    POS_THIRD  = 2'd2
  } grp_pos_e;

  // one classified byte: up to four characters, index of the last one,
  // and whether its last character closes the message
  typedef struct packed {
    logic [MAX_CHARS-1:0][6:0] chars;
    logic [1:0]                last_idx;
    logic                      fin;
  } job_t;

  // queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // standard base64 alphabet
  function automatic logic [6:0] sextet_char(input logic [5:0] v);
    logic [6:0] ch;
    if (v < 6'd26) begin
      ch = 7'h41 + {1'b0, v};
    end else if (v < 6'd52) begin
      ch = 7'h61 + {1'b0, v} - 7'd26;
    end else if (v < 6'd62) begin
      ch = 7'h30 + {1'b0, v} - 7'd52;
    end else if (v == 6'd62) begin
      ch = 7'h2B;
    end else begin
      ch = 7'h2F;
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/b64e_if.sv
// b64e_if: valid/ready channel interfaces for raw bytes and encoded characters
// depends on: nothing
`default_nettype none

interface b64e_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, data_byte, final_byte, input ready);
  modport sink   (input valid, data_byte, final_byte, output ready);
endinterface

interface b64e_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       final_char;

  modport source (output valid, out_char, final_char, input ready);
  modport sink   (input valid, out_char, final_char, output ready);
endinterface

`default_nettype wire

FILE: rtl/base64_stream_encoder.sv
// base64_stream_encoder: top level of the streaming base64 encoder
// depends on: b64e_pkg, b64e_if, b64e_front, b64e_queue, b64e_back
//
//   channel    dir  word                       handshake
//   byte_in    in   data_byte[7:0], final_byte valid / ready
//   char_out   out  out_char[6:0], final_char  valid / ready
//
// a byte is taken every cycle while the job queue (QueueDepth jobs) has room
// the back sends one character per cycle from its output register while a
// job is queued and char_out is not stalled, so the character channel sets
// the pace: 4 characters per 3 bytes, up to 4 for a final byte; a taken
// byte's job goes through the queue and the output register to char_out
// reset clears group position, leftover bits, queue and output valid
// a stalled char_out fills the queue and then drops byte_in.ready
`default_nettype none

module base64_stream_encoder
  import b64e_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  b64e_byte_if.sink   byte_in,
  b64e_char_if.source char_out
);

  q_status_t q_status;
  job_t      push_job;
  job_t      head_job;
  logic      push;
  logic      pop;

  b64e_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_in    (byte_in),
    .q_status_i (q_status),
    .push_o     (push),
    .job_o      (push_job)
  );

  b64e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (push_job),
    .pop_i    (pop),
    .head_o   (head_job),
    .status_o (q_status)
  );

  b64e_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head_job),
    .q_status_i (q_status),
    .pop_o      (pop),
    .char_out   (char_out)
  );

endmodule

`default_nettype wire

FILE: rtl/b64e_front.sv
// b64e_front: accepts raw bytes, tracks group position and leftover bits,
// and builds the character job for each byte
// depends on: b64e_pkg, b64e_if
`default_nettype none

module b64e_front
  import b64e_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  b64e_byte_if.sink      byte_in,
  input  q_status_t      q_status_i,
  output logic           push_o,
  output job_t           job_o
);

  grp_pos_e   pos_q, pos_d;
  logic [3:0] left_q, left_d;
  logic [7:0] b;
  logic       fin;

  assign b   = byte_in.data_byte;
  assign fin = byte_in.final_byte;

  // take a word whenever the queue has room
  assign byte_in.ready = !q_status_i.full;
  assign push_o        = byte_in.valid && !q_status_i.full;

  // next group position and leftover bits
  always_comb begin
    pos_d  = pos_q;
    left_d = left_q;
    if (push_o) begin
      case (pos_q)
        POS_SECOND: begin
          pos_d  = fin ? POS_FIRST : POS_THIRD;
          left_d = fin ? 4'd0 : b[3:0];
        end
        POS_THIRD: begin
          pos_d  = POS_FIRST;
          left_d = 4'd0;
        end
        default: begin
          pos_d  = fin ? POS_FIRST : POS_SECOND;
          left_d = fin ? 4'd0 : {2'b00, b[1:0]};
        end
      endcase
    end
  end

  // character job for the incoming byte
  always_comb begin
    job_o.chars    = {MAX_CHARS{PAD_CHAR}};
    job_o.last_idx = 2'd0;
    job_o.fin      = fin;
    case (pos_q)
      POS_SECOND: begin
        job_o.chars[0] = sextet_char({left_q[1:0], b[7:4]});
        if (fin) begin
          job_o.chars[1] = sextet_char({b[3:0], 2'b00});
          job_o.last_idx = 2'd2;
        end
      end
      POS_THIRD: begin
        job_o.chars[0] = sextet_char({left_q, b[7:6]});
        job_o.chars[1] = sextet_char(b[5:0]);
        job_o.last_idx = 2'd1;
      end
      default: begin
        job_o.chars[0] = sextet_char(b[7:2]);
        if (fin) begin
          job_o.chars[1] = sextet_char({b[1:0], 4'b0000});
          job_o.last_idx = 2'd3;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= POS_FIRST;
      left_q <= 4'd0;
    end else begin
      pos_q  <= pos_d;
      left_q <= left_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/b64e_queue.sv
// b64e_queue: short first-in first-out queue of character jobs between
// the front and the back
// depends on: b64e_pkg
`default_nettype none

module b64e_queue
  import b64e_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  job_t      job_i,
  input  logic      pop_i,
  output job_t      head_o,
  output q_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;

  assign status_o.full  = (cnt_q == FullCnt);
  assign status_o.empty = (cnt_q == '0);
  assign head_o         = mem_q[rd_ptr_q];
  assign do_pop         = pop_i && !status_o.empty;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // job storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/b64e_back.sv
// b64e_back: walks the characters of the head job onto the output register
// depends on: b64e_pkg, b64e_if
`default_nettype none

module b64e_back
  import b64e_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  job_t        head_i,
  input  q_status_t   q_status_i,
  output logic        pop_o,
  b64e_char_if.source char_out
);

  logic       out_valid_q, out_valid_d;
  logic [6:0] out_char_q, out_char_d;
  logic       out_final_q, out_final_d;
  logic [1:0] idx_q, idx_d;
  logic       load;
  logic       take;
  logic       at_last;

  // output register may refill when empty or being drained
  assign load    = !out_valid_q || char_out.ready;
  assign take    = load && !q_status_i.empty;
  assign at_last = (idx_q == head_i.last_idx);
  assign pop_o   = take && at_last;

  always_comb begin
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_final_d = out_final_q;
    idx_d       = idx_q;
    if (load) begin
      out_valid_d = !q_status_i.empty;
    end
    if (take) begin
      out_char_d  = head_i.chars[idx_q];
      out_final_d = head_i.fin && at_last;
      idx_d       = at_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  // character payload
  always_ff @(posedge clk_i) begin
    out_char_q  <= out_char_d;
    out_final_q <= out_final_d;
  end

  assign char_out.valid      = out_valid_q;
  assign char_out.out_char   = out_char_q;
  assign char_out.final_char = out_final_q;

endmodule

`default_nettype wire

FILE: rtl/b64e_checker.sv
// b64e_checker: port-level checks of the base64 stream encoder
// depends on: base64_stream_encoder (bound to it at the end of this file)
`default_nettype none

module b64e_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_final_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [6:0] out_char_i,
  input logic       out_final_i
);

  logic [1:0] pos_q, pos_d;
  logic [7:0] pend_q, pend_d;
  logic [3:0] msgs_q, msgs_d;
  logic       open_q, open_d;
  logic [2:0] n_in;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // characters owed for the accepted word
  always_comb begin
    case (pos_q)
      2'd1:    n_in = in_final_i ? 3'd3 : 3'd1;
      2'd2:    n_in = 3'd2;
      default: n_in = in_final_i ? 3'd4 : 3'd1;
    endcase
  end

  // model of outstanding characters, open messages and a message still being fed
  always_comb begin
    pos_d  = pos_q;
    pend_d = pend_q;
    msgs_d = msgs_q;
    open_d = open_q;
    if (in_acc) begin
      pos_d  = (in_final_i || pos_q == 2'd2) ? 2'd0 : pos_q + 2'd1;
      open_d = !in_final_i;
    end
    pend_d = pend_q + (in_acc ? {5'd0, n_in} : 8'd0) - (out_acc ? 8'd1 : 8'd0);
    msgs_d = msgs_q + ((in_acc && in_final_i) ? 4'd1 : 4'd0)
                    - ((out_acc && out_final_i) ? 4'd1 : 4'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 2'd0;
      pend_q <= 8'd0;
      msgs_q <= 4'd0;
      open_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      pend_q <= pend_d;
      msgs_q <= msgs_d;
      open_q <= open_d;
    end
  end

  // a stalled character holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_char_i)
      && $stable(out_final_i))
    else $error("char_out word changed while stalled");

  // no character without a byte that owes it
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 8'd0)
    else $error("character shown with none outstanding");

  // final flag only for a message whose final byte went in
  a_final_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_final_i |-> msgs_q != 4'd0)
    else $error("final character without a final byte");

  // a final character is the last one its message owes
  a_final_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_final_i && msgs_q == 4'd1 && !open_q && !in_acc
      |=> pend_q == 8'd0)
    else $error("characters left over after the final one");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (byte_in.valid),
  .in_ready_i  (byte_in.ready),
  .in_final_i  (byte_in.final_byte),
  .out_valid_i (char_out.valid),
  .out_ready_i (char_out.ready),
  .out_char_i  (char_out.out_char),
  .out_final_i (char_out.final_char)
);

`default_nettype wire

FILE: tb/tb_base64_stream_encoder.sv
// tb_base64_stream_encoder: self-checking bench for the streaming base64 encoder
// predicts every character and its final flag, under random idling and back-pressure
// depends on: b64e_pkg, b64e_if, base64_stream_encoder
`timescale 1ns / 1ps

module tb_base64_stream_encoder;
  import b64e_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam string B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } raw_byte_t;

  typedef struct packed {
    logic [6:0] ch;
    logic       fin;
  } enc_char_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  b64e_byte_if byte_in ();
  b64e_char_if char_out ();

  base64_stream_encoder dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_in  (byte_in),
    .char_out (char_out)
  );

  raw_byte_t   pending_bytes[$];
  enc_char_t   expected_chars[$];
  raw_byte_t   next_byte;
  enc_char_t   got_char;
  enc_char_t   want_char;
  grp_pos_e    grp_pos;
  logic [3:0]  leftover;
  logic        byte_fire;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_len;
  int unsigned quiet_cycles;
  int unsigned err_cnt;

  // clock
  always #5 clk_i = ~clk_i;

  function automatic logic [6:0] sextet_ascii(input logic [5:0] v);
    return 7'(B64_ALPHABET[v]);
  endfunction

  function automatic void push_expected(input logic [6:0] ch, input logic fin);
    expected_chars.push_back('{ch: ch, fin: fin});
  endfunction

  // group position and leftover bits decide which characters a word completes
  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    case (grp_pos)
      POS_SECOND: begin
        push_expected(sextet_ascii({leftover[1:0], b[7:4]}), 1'b0);
        if (fin) begin
          push_expected(sextet_ascii({b[3:0], 2'b00}), 1'b0);
          push_expected(PAD_CHAR, 1'b1);
          grp_pos = POS_FIRST;
          leftover = '0;
        end else begin
          grp_pos = POS_THIRD;
          leftover = b[3:0];
        end
      end
      POS_THIRD: begin
        push_expected(sextet_ascii({leftover, b[7:6]}), 1'b0);
        push_expected(sextet_ascii(b[5:0]), fin);
        grp_pos = POS_FIRST;
        leftover = '0;
      end
      default: begin
        push_expected(sextet_ascii(b[7:2]), 1'b0);
        if (fin) begin
          push_expected(sextet_ascii({b[1:0], 4'b0000}), 1'b0);
          push_expected(PAD_CHAR, 1'b0);
          push_expected(PAD_CHAR, 1'b1);
          grp_pos = POS_FIRST;
          leftover = '0;
        end else begin
          grp_pos = POS_SECOND;
          leftover = {2'b00, b[1:0]};
        end
      end
    endcase
  endfunction

  // byte word driver, fed from the pending queue
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      byte_in.valid <= 1'b0;
    end else if (!byte_in.valid || byte_fire) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_byte = pending_bytes.pop_front();
        byte_in.valid      <= 1'b1;
        byte_in.data_byte  <= next_byte.data;
        byte_in.final_byte <= next_byte.fin;
      end else begin
        byte_in.valid <= 1'b0;
      end
    end
  end

  // character receiver: long hold-off first, then random stalls
  always @(negedge clk_i) begin
    if (hold_len != 0) begin
      hold_len <= hold_len - 1;
      char_out.ready <= 1'b0;
    end else begin
      char_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: prediction on accepted bytes, check on accepted characters, watchdog
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      byte_fire <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      byte_fire <= byte_in.valid && byte_in.ready;
      if (byte_in.valid && byte_in.ready) begin
        encode_byte(byte_in.data_byte, byte_in.final_byte);
      end
      if (char_out.valid && char_out.ready) begin
        got_char = '{ch: char_out.out_char, fin: char_out.final_char};
        if (expected_chars.size() == 0) begin
          $error("unexpected character %h, final %b", got_char.ch, got_char.fin);
          err_cnt++;
        end else begin
          want_char = expected_chars.pop_front();
          if (got_char.ch !== want_char.ch) begin
            $error("out_char: expected %h, got %h", want_char.ch, got_char.ch);
            err_cnt++;
          end
          if (got_char.fin !== want_char.fin) begin
            $error("final_char: expected %b, got %b", want_char.fin, got_char.fin);
            err_cnt++;
          end
        end
      end
      if ((byte_in.valid && byte_in.ready) || (char_out.valid && char_out.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
        $display("tb_base64_stream_encoder: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic queue_message(input logic [7:0] bytes[$]);
    foreach (bytes[i]) begin
      pending_bytes.push_back('{data: bytes[i], fin: (i == bytes.size() - 1)});
    end
  endtask

  // random message content, mostly short, now and then a long one
  task automatic queue_random_messages(input int unsigned n_items);
    int unsigned added;
    int unsigned len;
    logic [7:0]  bytes[$];
    added = 0;
    while (added < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 7);
      bytes.delete();
      repeat (len) bytes.push_back(8'($urandom_range(255)));
      queue_message(bytes);
      added += len;
    end
  endtask

  // sender holds back until every queued word is through and every character is in
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || byte_in.valid || expected_chars.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    err_cnt = 0;
    grp_pos = POS_FIRST;
    leftover = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_len = 0;
    rst_ni = 1'b0;
    byte_in.valid = 1'b0;
    byte_in.data_byte = '0;
    byte_in.final_byte = 1'b0;
    char_out.ready = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: final byte at each group position, extreme bytes, '+' and '/'
    queue_message('{8'h00});
    queue_message('{8'hFF});
    queue_message('{8'h00, 8'hFF});
    queue_message('{8'hFF, 8'h00});
    queue_message('{8'h00, 8'h00, 8'h00});
    queue_message('{8'hFF, 8'hFF, 8'hFF});
    queue_message('{8'hFB, 8'hEF, 8'hBF});
    queue_message('{8'h4D, 8'h61, 8'h6E, 8'h4D, 8'h61});
    wait_drained();

    // no idling on either side
    queue_random_messages(60);
    wait_drained();

    // sender mostly idle
    send_idle_pct = 66;
    queue_random_messages(55);
    wait_drained();

    // receiver mostly stalling
    send_idle_pct = 0;
    recv_stall_pct = 66;
    queue_random_messages(55);
    wait_drained();

    // light idling on both sides
    send_idle_pct = 18;
    recv_stall_pct = 18;
    queue_random_messages(55);
    wait_drained();

    // long receiver hold-off while bytes keep coming, so the input backs up
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_len = 300;
    queue_random_messages(50);
    wait_drained();

    if (err_cnt == 0) begin
      $display("tb_base64_stream_encoder: PASS");
    end else begin
      $display("tb_base64_stream_encoder: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/b64e_pkg.sv
rtl/b64e_if.sv
rtl/b64e_front.sv
rtl/b64e_queue.sv
rtl/b64e_back.sv
rtl/base64_stream_encoder.sv
rtl/b64e_checker.sv
tb/tb_base64_stream_encoder.sv
